@@ rtl/tbcr_pkg.sv @@
// Shared types and constants for the tilemap box collision resolver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tbcr_pkg;
    localparam int FRAC_BITS = 8;
    localparam int POS_W     = 24;
    // wide working width for the running position during pushes
    localparam int WORK_W    = 28;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    localparam logic [0:0] REG_MAP_COLS = 1'b0;
    localparam logic [0:0] REG_MAP_ROWS = 1'b1;

    // one probe result travelling down the pipe
    typedef struct packed {
        logic       vld;
        logic [7:0] col;
        logic [7:0] row;
    } probe_t;

    // per-item control traveling with the data
    typedef struct packed {
        logic vld;
        logic cmd;
    } ctl_t;
endpackage
`default_nettype wire

@@ rtl/tbcr_push.sv @@
// Pipeline parts: one push stage that applies a solid tile to the running position,
// and the generic registered-read RAM that holds the tile map copies.
// Depends on tbcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbcr_push
    import tbcr_pkg::*;
#(
    parameter int TILE_SHIFT = 6,
    parameter int AGENT_HALF = 30
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ctl_t                     ctl_in,
    input  wire logic                     hit_in,
    input  wire logic signed [WORK_W-1:0] x_in,
    input  wire logic signed [WORK_W-1:0] y_in,
    input  wire logic                     tvld,
    input  wire logic [7:0]               tcol,
    input  wire logic [7:0]               trow,
    output ctl_t                          ctl_out,
    output logic                          hit_out,
    output logic signed [WORK_W-1:0]      x_out,
    output logic signed [WORK_W-1:0]      y_out
);
    localparam int K = TILE_SHIFT + FRAC_BITS;
    localparam logic signed [WORK_W-1:0] HALF =
        WORK_W'(AGENT_HALF << FRAC_BITS);
    localparam logic signed [WORK_W-1:0] PUSH_REACH =
        WORK_W'((AGENT_HALF << FRAC_BITS) + (1 << (K - 1)));
    localparam logic signed [WORK_W-1:0] TOFF = WORK_W'(1 << (K - 1));

    ctl_t                     ctl_reg;
    logic                     hit_reg;
    logic signed [WORK_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [WORK_W-1:0] tx, ty, dx, dy, ax, ay, xd, yd, px, py;

    // depths against the tile centre
    always_comb
    begin
        tx = (WORK_W'({20'd0, tcol}) <<< K) + TOFF;
        ty = (WORK_W'({20'd0, trow}) <<< K) + TOFF;
        dx = x_in + HALF - tx;
        dy = y_in + HALF - ty;
        ax = dx[WORK_W-1] ? -dx : dx;
        ay = dy[WORK_W-1] ? -dy : dy;
        xd = PUSH_REACH - ax;
        yd = PUSH_REACH - ay;
        px = (xd > 0) ? xd : '0;
        py = (yd > 0) ? yd : '0;
        x_next = x_in;
        y_next = y_in;
        if (tvld && ((xd > 0) || (yd > 0)))
        begin
            if (px < py)
                x_next = dx[WORK_W-1] ? x_in - xd : x_in + xd;
            else
                y_next = dy[WORK_W-1] ? y_in - yd : y_in + yd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_in;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign ctl_out = ctl_reg;
    assign hit_out = hit_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
endmodule

// Simple dual-port RAM: one write port, one registered read port (old data on collision).
module tbcr_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
)(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ rtl/tilemap_box_collision_resolve.sv @@
// Top level: tile map copies, corner probe stages, four push stages, output.
// Depends on tbcr_pkg, tbcr_push and tbcr_ram.
//
// Usage: an item is taken on a clk edge with start high and busy low. cmd 0
// writes one tile bit; cmd 1 resolves an agent position against the four
// corner tiles. Each item gives one result on new_x/new_y/hit with done high
// for one cycle, once the item has passed the stage 1 and stage 2 registers,
// the four push stages and the output register; writes give zeros.
// Throughput is one item per cycle while busy is low: the map is held in
// four RAM copies, each read at one corner address with registered data,
// then four push stages apply the corner tiles in order. Writes update every
// copy at their transfer edge, so a resolve taken in a later cycle sees them.
// Reset sets map_cols/map_rows to 64 and starts a clearing pass over the map:
// busy stays high after reset release while every map address is cleared, then
// stays low. Configuration writes (cfg_valid/cfg_ready, always ready) are taken
// any cycle. The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none
module tilemap_box_collision_resolve
    import tbcr_pkg::*;
#(
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64,
    parameter int TILE_SHIFT = 6,
    parameter int AGENT_SIZE = 60,
    parameter int AGENT_HALF = 30
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    cmd,
    input  wire logic [5:0]              tile_col,
    input  wire logic [5:0]              tile_row,
    input  wire logic                    tile_solid,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    output logic                         done,
    output logic signed [POS_W-1:0]      new_x,
    output logic signed [POS_W-1:0]      new_y,
    output logic                         hit,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [0:0]              cfg_index,
    input  wire logic [6:0]              cfg_data
);
    localparam int K = TILE_SHIFT + FRAC_BITS;
    localparam int NT = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (NT > 1) ? $clog2(NT) : 1;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(NT - 1);
    localparam logic signed [WORK_W-1:0] SIZE = WORK_W'(AGENT_SIZE << FRAC_BITS);
    localparam logic [8:0] MC = 9'(MAX_COLS);
    localparam logic [8:0] MR = 9'(MAX_ROWS);

    logic [6:0]        cols_reg, rows_reg;
    logic              acc;
    logic              clr_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              map_we;
    logic [ADDR_W-1:0] map_waddr;
    logic              map_wdata;

    assign busy      = clr_reg;
    assign cfg_ready = 1'b1;
    assign acc       = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 7'd64;
            rows_reg <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_COLS: cols_reg <= cfg_data;
                REG_MAP_ROWS: rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clearing pass over the map after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == CLR_LAST)
                clr_reg <= 1'b0;
        end
    end

    // map write port: clearing pass, else tile writes on accept
    always_comb
    begin
        if (clr_reg)
        begin
            map_we    = 1'b1;
            map_waddr = clr_addr_reg;
            map_wdata = 1'b0;
        end
        else
        begin
            map_we    = acc && cmd == CMD_WRITE && 9'(tile_col) < MC && 9'(tile_row) < MR;
            map_waddr = ADDR_W'(int'(tile_row) * MAX_COLS + int'(tile_col));
            map_wdata = tile_solid;
        end
    end

    // stage 1: register the agent position
    ctl_t                     c1_reg;
    logic signed [WORK_W-1:0] x1_reg, y1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_reg <= '0;
        else
            c1_reg <= '{vld: acc, cmd: cmd};
    end
    always_ff @(posedge clk)
    begin
        x1_reg <= WORK_W'(pos_x);
        y1_reg <= WORK_W'(pos_y);
    end

    // stage 2: floor corners, bounds, map read addresses
    logic [8:0] lim_c, lim_r;
    assign lim_c = (9'(cols_reg) > MC) ? MC : 9'(cols_reg);
    assign lim_r = (9'(rows_reg) > MR) ? MR : 9'(rows_reg);

    probe_t            p_next  [4];
    probe_t            p_reg   [4];
    probe_t            p_eff   [4];
    logic [ADDR_W-1:0] rd_addr [4];
    logic              rd_q    [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [WORK_W-1:0] cx, cy, fc, fr;
            cx = (i % 2 == 1) ? x1_reg + SIZE : x1_reg;
            cy = (i >= 2)     ? y1_reg + SIZE : y1_reg;
            fc = cx >>> K;
            fr = cy >>> K;
            p_next[i].col = fc[7:0];
            p_next[i].row = fr[7:0];
            p_next[i].vld = !fc[WORK_W-1] && !fr[WORK_W-1]
                && (fc < WORK_W'(lim_c)) && (fr < WORK_W'(lim_r));
            rd_addr[i] = ADDR_W'(int'(fr[7:0]) * MAX_COLS + int'(fc[7:0]));
        end
    end

    // one map copy per corner, read data registered with the stage
    for (genvar g = 0; g < 4; g++)
    begin : g_map
        tbcr_ram #(.WIDTH(1), .DEPTH(NT), .ADDR_W(ADDR_W)) u_map (
            .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
            .raddr(rd_addr[g]), .rdata(rd_q[g])
        );
    end

    ctl_t                     c2_reg;
    logic signed [WORK_W-1:0] x2_reg, y2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_reg <= '0;
        else
            c2_reg <= c1_reg;
    end
    always_ff @(posedge clk)
    begin
        x2_reg <= x1_reg;
        y2_reg <= y1_reg;
        for (int i = 0; i < 4; i++)
            p_reg[i] <= p_next[i];
    end

    // corner is solid only when inside the map and the tile bit is set
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            p_eff[i]     = p_reg[i];
            p_eff[i].vld = p_reg[i].vld & rd_q[i];
        end
    end

    // tile delay lines so each push stage sees its own corner
    probe_t d1_reg [3];
    probe_t d2_reg [2];
    probe_t d3_reg;
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            d1_reg[i] <= p_eff[i+1];
        d2_reg[0] <= d1_reg[1];
        d2_reg[1] <= d1_reg[2];
        d3_reg    <= d2_reg[1];
    end

    // push stages 3..6
    ctl_t                     cs [5];
    logic                     hs [5];
    logic signed [WORK_W-1:0] xs [5];
    logic signed [WORK_W-1:0] ys [5];
    probe_t                   tp [4];
    assign cs[0] = c2_reg;
    assign hs[0] = p_eff[0].vld | p_eff[1].vld | p_eff[2].vld | p_eff[3].vld;
    assign xs[0] = x2_reg;
    assign ys[0] = y2_reg;
    assign tp[0] = p_eff[0];
    assign tp[1] = d1_reg[0];
    assign tp[2] = d2_reg[0];
    assign tp[3] = d3_reg;

    for (genvar g = 0; g < 4; g++)
    begin : g_push
        tbcr_push #(.TILE_SHIFT(TILE_SHIFT), .AGENT_HALF(AGENT_HALF)) u_push (
            .clk(clk), .rst_n(rst_n),
            .ctl_in(cs[g]), .hit_in(hs[g]), .x_in(xs[g]), .y_in(ys[g]),
            .tvld(tp[g].vld), .tcol(tp[g].col), .trow(tp[g].row),
            .ctl_out(cs[g+1]), .hit_out(hs[g+1]), .x_out(xs[g+1]), .y_out(ys[g+1])
        );
    end

    // output: saturate and register
    localparam logic signed [WORK_W-1:0] PMAX = WORK_W'(8388607);
    localparam logic signed [WORK_W-1:0] PMIN = -WORK_W'(8388608);
    logic                     done_reg, hit_reg;
    logic signed [POS_W-1:0]  nx_reg, ny_reg, nx_next, ny_next;
    logic                     res;
    assign res = cs[4].cmd == CMD_RESOLVE;
    always_comb
    begin
        nx_next = (xs[4] > PMAX) ? POS_W'(PMAX) : (xs[4] < PMIN) ? POS_W'(PMIN)
                  : xs[4][POS_W-1:0];
        ny_next = (ys[4] > PMAX) ? POS_W'(PMAX) : (ys[4] < PMIN) ? POS_W'(PMIN)
                  : ys[4][POS_W-1:0];
        if (!res)
        begin
            nx_next = '0;
            ny_next = '0;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cs[4].vld;
    end
    always_ff @(posedge clk)
    begin
        nx_reg  <= nx_next;
        ny_reg  <= ny_next;
        hit_reg <= res & hs[4];
    end

    assign done  = done_reg;
    assign new_x = nx_reg;
    assign new_y = ny_reg;
    assign hit   = hit_reg;
endmodule
`default_nettype wire
